FILE: rtl/core/rcms_pkg.sv
package rcms_pkg;

	localparam int CNT_W = 21;
	localparam int SUM_W = 42;
	localparam int NV_W  = 32;
	localparam int TAG_W = 31;
	localparam int ANS_W = 41;

	localparam logic [1:0] CMD_CHMIN = 2'd0;
	localparam logic [1:0] CMD_MAXQ  = 2'd1;
	localparam logic [1:0] CMD_SUMQ  = 2'd2;
	localparam logic [1:0] CMD_LOAD  = 2'd3;

	typedef struct packed {
		logic signed [NV_W-1:0] mx;
		logic signed [NV_W-1:0] sec;
		logic [CNT_W-1:0]       cnt;
		logic [SUM_W-1:0]       sum;
		logic                   tag_v;
		logic [TAG_W-1:0]       tag;
	} node_t;

	localparam node_t NODE_RESET = '{
		mx: -32'sd1,
		sec: -32'sd1,
		cnt: '0,
		sum: '0,
		tag_v: 1'b0,
		tag: '0
	};

endpackage

FILE: rtl/core/rcms_node_ram.sv
module rcms_node_ram #(
	parameter int DEPTH = 4096,
	parameter int ADDR_W = 12
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  rcms_pkg::node_t     wr_data,
	output rcms_pkg::node_t     rd_data
);
	import rcms_pkg::*;

	node_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/rcms_pull.sv
module rcms_pull (
	input  rcms_pkg::node_t a,
	input  rcms_pkg::node_t b,
	output rcms_pkg::node_t p
);
	import rcms_pkg::*;

	always_comb begin
		p = NODE_RESET;
		p.sum = a.sum + b.sum;
		if (a.mx == b.mx) begin
			p.mx = a.mx;
			p.cnt = a.cnt + b.cnt;
			p.sec = (a.sec > b.sec) ? a.sec : b.sec;
		end else if (a.mx < b.mx) begin
			p.mx = b.mx;
			p.cnt = b.cnt;
			p.sec = (b.sec > a.mx) ? b.sec : a.mx;
		end else begin
			p.mx = a.mx;
			p.cnt = a.cnt;
			p.sec = (b.mx > a.sec) ? b.mx : a.sec;
		end
	end

endmodule

FILE: rtl/core/rcms_cap.sv
module rcms_cap (
	input  logic                       clk,
	input  rcms_pkg::node_t            node_i,
	input  logic [rcms_pkg::TAG_W-1:0] x_i,
	output rcms_pkg::node_t            node_o
);
	import rcms_pkg::*;

	logic [NV_W-1:0]       diff;
	logic [CNT_W+NV_W-1:0] prod_s1;
	node_t                 node_s1;
	logic [TAG_W-1:0]      x_s1;

	assign diff = node_i.mx - $signed({1'b0, x_i});

	always_ff @(posedge clk) begin
		prod_s1 <= (CNT_W+NV_W)'(node_i.cnt) * (CNT_W+NV_W)'(diff);
		node_s1 <= node_i;
		x_s1 <= x_i;
	end

	always_comb begin
		node_o = node_s1;
		node_o.sum = node_s1.sum - prod_s1[SUM_W-1:0];
		node_o.mx = $signed({1'b0, x_s1});
		node_o.tag_v = 1'b1;
		node_o.tag = x_s1;
	end

endmodule

FILE: rtl/core/range_chmin_max_sum_tree.sv
// Range-chmin segment tree with range maximum and range sum queries.
// A command word (cmd, lo, hi, value) is taken when start is high and busy
// is low. Commands are range chmin, range max, range sum and single element
// load. Only the two queries return a word: answer and is_sum appear for
// exactly one cycle with answer_valid high, and the receiver cannot stall.
// Every command but an out of range load walks the tree one node at a time
// through a single node memory with a registered read. A visited node is
// read, then evaluated; pushing down a tag reads the children and caps them
// where needed, then writes the parent; a cap registers a product, then
// writes the node; rebuilding a parent reads both children, then writes it.
// A query visits about 4*log2(n) nodes and a chmin a data dependent number
// that averages O(log^2 n). The next command can be taken in the cycle that
// carries the answer, or once S_POP and S_DONE follow the last node write of
// a chmin or a load. After reset all 4*MAX_ELEMENTS node memory entries are
// cleared, one entry per cycle, with busy high. The APB port holds
// element_count at address 0 and is served during the clear as well.
module range_chmin_max_sum_tree #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int VALUE_BITS = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [1:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 cmd,
	input  logic [10:0]                lo,
	input  logic [10:0]                hi,
	input  logic [30:0]                value,
	output logic                       answer_valid,
	output logic [rcms_pkg::ANS_W-1:0] answer,
	output logic                       is_sum
);
	import rcms_pkg::*;

	localparam int NODES = 4 * MAX_ELEMENTS;
	localparam int NODE_W = $clog2(NODES);
	localparam int IDX_W = $clog2(MAX_ELEMENTS + 1);
	localparam int PW = (IDX_W > 11) ? IDX_W : 11;
	localparam int STK_D = $clog2(MAX_ELEMENTS) + 1;
	localparam int STK_IW = $clog2(STK_D);
	localparam int SP_W = $clog2(STK_D + 1);
	localparam logic [TAG_W-1:0] VMASK = TAG_W'((64'd1 << VALUE_BITS) - 64'd1);
	localparam logic [PW-1:0] MAX_N = PW'(MAX_ELEMENTS);

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_RD    = 5'd2;
	localparam logic [4:0] S_EVAL  = 5'd3;
	localparam logic [4:0] S_PRA   = 5'd4;
	localparam logic [4:0] S_PCA   = 5'd5;
	localparam logic [4:0] S_PRB   = 5'd6;
	localparam logic [4:0] S_PCB   = 5'd7;
	localparam logic [4:0] S_PWO   = 5'd8;
	localparam logic [4:0] S_DESC  = 5'd9;
	localparam logic [4:0] S_POP   = 5'd10;
	localparam logic [4:0] S_RET   = 5'd11;
	localparam logic [4:0] S_LRA   = 5'd12;
	localparam logic [4:0] S_LRB   = 5'd13;
	localparam logic [4:0] S_LW    = 5'd14;
	localparam logic [4:0] S_CAP1  = 5'd15;
	localparam logic [4:0] S_CAP2  = 5'd16;
	localparam logic [4:0] S_DONE  = 5'd17;

	localparam logic PH_L = 1'b0;
	localparam logic PH_R = 1'b1;

	typedef struct packed {
		logic [NODE_W-1:0] o;
		logic [PW-1:0]     l;
		logic [PW-1:0]     r;
		logic              ph;
	} frame_t;

	logic [4:0]        state_q;
	logic [4:0]        ret_q;
	logic [NODE_W-1:0] clr_q;
	logic [10:0]       ec_q;
	logic [1:0]        cmd_q;
	logic [PW-1:0]     lo_q;
	logic [PW-1:0]     hi_q;
	logic [TAG_W-1:0]  x_q;
	logic [SUM_W-1:0]  acc_q;
	frame_t            cur_q;
	frame_t            stk_q [STK_D];
	logic [SP_W-1:0]   sp_q;
	node_t             nd_q;
	node_t             a_q;
	node_t             cap_nd_q;
	logic [TAG_W-1:0]  cap_x_q;
	logic [NODE_W-1:0] cap_addr_q;
	logic              res_v_q;
	logic [ANS_W-1:0]  res_q;
	logic              res_sum_q;

	logic              rd_en;
	logic [NODE_W-1:0] rd_addr;
	logic              wr_en;
	logic [NODE_W-1:0] wr_addr;
	node_t             wr_data;
	node_t             rd_data;
	node_t             pull_nd;
	node_t             cap_nd;
	node_t             leaf_nd;
	node_t             clr_nd;

	logic [PW-1:0]     n_eff;
	logic [PW-1:0]     ec_ext;
	logic [NODE_W-1:0] o_left;
	logic [NODE_W-1:0] o_right;
	logic [PW:0]       lr_sum;
	logic [PW-1:0]     mid;
	logic              disj;
	logic              cov;
	logic              leaf;
	logic signed [NV_W-1:0] x_s;
	logic [SUM_W-1:0]  nmax;
	logic              cfg_wr;
	logic              is_query;

	rcms_node_ram #(.DEPTH(NODES), .ADDR_W(NODE_W)) u_ram (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	rcms_pull u_pull (
		.a(a_q),
		.b(rd_data),
		.p(pull_nd)
	);

	rcms_cap u_cap (
		.clk(clk),
		.node_i(cap_nd_q),
		.x_i(cap_x_q),
		.node_o(cap_nd)
	);

	assign ec_ext = PW'(ec_q);
	assign n_eff = (ec_ext == '0) ? PW'(1) : ((ec_ext > MAX_N) ? MAX_N : ec_ext);
	assign o_left = {cur_q.o[NODE_W-2:0], 1'b0};
	assign o_right = {cur_q.o[NODE_W-2:0], 1'b1};
	assign lr_sum = {1'b0, cur_q.l} + {1'b0, cur_q.r};
	assign mid = lr_sum[PW:1];
	assign disj = (lo_q > cur_q.r) || (hi_q < cur_q.l);
	assign cov = (lo_q <= cur_q.l) && (cur_q.r <= hi_q);
	assign leaf = (cur_q.l == cur_q.r);
	assign x_s = $signed({1'b0, x_q});
	assign nmax = rd_data.mx[NV_W-1] ? '0 : SUM_W'(rd_data.mx);
	assign is_query = (cmd_q == CMD_MAXQ) || (cmd_q == CMD_SUMQ);
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		leaf_nd = NODE_RESET;
		leaf_nd.mx = x_s;
		leaf_nd.cnt = CNT_W'(1);
		leaf_nd.sum = SUM_W'(x_q);
		clr_nd = NODE_RESET;
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = cur_q.o;
		wr_en = 1'b0;
		wr_addr = cur_q.o;
		wr_data = clr_nd;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
			end
			S_RD: begin
				rd_en = 1'b1;
			end
			S_PRA, S_LRA: begin
				rd_en = 1'b1;
				rd_addr = o_left;
			end
			S_PRB, S_LRB: begin
				rd_en = 1'b1;
				rd_addr = o_right;
			end
			S_EVAL: begin
				if (cmd_q == CMD_LOAD && leaf) begin
					wr_en = 1'b1;
					wr_data = leaf_nd;
				end
			end
			S_PWO: begin
				wr_en = 1'b1;
				wr_data = nd_q;
				wr_data.tag_v = 1'b0;
			end
			S_CAP2: begin
				wr_en = 1'b1;
				wr_addr = cap_addr_q;
				wr_data = cap_nd;
			end
			S_LW: begin
				wr_en = 1'b1;
				wr_data = pull_nd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q <= S_IDLE;
			clr_q <= '0;
			ec_q <= 11'd1024;
			sp_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= 1'b0;
			if (cfg_wr && paddr == 2'd0) begin
				ec_q <= pwdata[10:0];
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						lo_q <= PW'(lo);
						hi_q <= PW'(hi);
						x_q <= value & VMASK;
						acc_q <= '0;
						sp_q <= '0;
						cur_q <= '{o: NODE_W'(1), l: PW'(1), r: n_eff, ph: PH_L};
						if (cmd == CMD_LOAD && (lo == 11'd0 || PW'(lo) > n_eff)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					nd_q <= rd_data;
					case (cmd_q)
						CMD_CHMIN: begin
							if (disj || rd_data.mx <= x_s) begin
								state_q <= S_POP;
							end else if (cov && rd_data.sec < x_s) begin
								cap_nd_q <= rd_data;
								cap_x_q <= x_q;
								cap_addr_q <= cur_q.o;
								ret_q <= S_POP;
								state_q <= S_CAP1;
							end else if (leaf) begin
								state_q <= S_POP;
							end else begin
								state_q <= rd_data.tag_v ? S_PRA : S_DESC;
							end
						end
						CMD_LOAD: begin
							if (leaf) begin
								state_q <= S_POP;
							end else begin
								state_q <= rd_data.tag_v ? S_PRA : S_DESC;
							end
						end
						default: begin
							if (disj) begin
								state_q <= S_POP;
							end else if (cov || leaf) begin
								if (cmd_q == CMD_SUMQ) begin
									acc_q <= acc_q + rd_data.sum;
								end else if (nmax > acc_q) begin
									acc_q <= nmax;
								end
								state_q <= S_POP;
							end else begin
								state_q <= rd_data.tag_v ? S_PRA : S_DESC;
							end
						end
					endcase
				end
				S_PRA: begin
					state_q <= S_PCA;
				end
				S_PCA: begin
					cap_nd_q <= rd_data;
					cap_x_q <= nd_q.tag;
					cap_addr_q <= o_left;
					ret_q <= S_PRB;
					state_q <= (rd_data.mx > $signed({1'b0, nd_q.tag})) ? S_CAP1 : S_PRB;
				end
				S_PRB: begin
					state_q <= S_PCB;
				end
				S_PCB: begin
					cap_nd_q <= rd_data;
					cap_x_q <= nd_q.tag;
					cap_addr_q <= o_right;
					ret_q <= S_PWO;
					state_q <= (rd_data.mx > $signed({1'b0, nd_q.tag})) ? S_CAP1 : S_PWO;
				end
				S_PWO: begin
					state_q <= S_DESC;
				end
				S_DESC: begin
					stk_q[sp_q[STK_IW-1:0]] <= '{o: cur_q.o, l: cur_q.l, r: cur_q.r,
						ph: (cmd_q == CMD_LOAD) ? PH_R : PH_L};
					sp_q <= sp_q + SP_W'(1);
					if (cmd_q == CMD_LOAD && lo_q > mid) begin
						cur_q <= '{o: o_right, l: mid + PW'(1), r: cur_q.r, ph: PH_L};
					end else begin
						cur_q <= '{o: o_left, l: cur_q.l, r: mid, ph: PH_L};
					end
					state_q <= S_RD;
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_DONE;
					end else begin
						cur_q <= stk_q[STK_IW'(sp_q - SP_W'(1))];
						sp_q <= sp_q - SP_W'(1);
						state_q <= S_RET;
					end
				end
				S_RET: begin
					if (cur_q.ph == PH_L) begin
						stk_q[sp_q[STK_IW-1:0]] <= '{o: cur_q.o, l: cur_q.l, r: cur_q.r,
							ph: PH_R};
						sp_q <= sp_q + SP_W'(1);
						cur_q <= '{o: o_right, l: mid + PW'(1), r: cur_q.r, ph: PH_L};
						state_q <= S_RD;
					end else if (is_query) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_LRA;
					end
				end
				S_LRA: begin
					state_q <= S_LRB;
				end
				S_LRB: begin
					a_q <= rd_data;
					state_q <= S_LW;
				end
				S_LW: begin
					state_q <= S_POP;
				end
				S_CAP1: begin
					state_q <= S_CAP2;
				end
				S_CAP2: begin
					state_q <= ret_q;
				end
				S_DONE: begin
					if (is_query) begin
						res_v_q <= 1'b1;
						res_q <= acc_q[ANS_W-1:0];
						res_sum_q <= (cmd_q == CMD_SUMQ);
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign answer_valid = res_v_q;
	assign answer = res_q;
	assign is_sum = res_sum_q;
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {21'd0, ec_q} : 32'd0;

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid |=> !answer_valid)
		else $error("answer strobe held for more than one cycle");

	a_max_range: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && !is_sum |-> answer[ANS_W-1:VALUE_BITS] == '0)
		else $error("range maximum wider than an element");

	a_stack: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STK_D))
		else $error("node stack overflow");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command taken without going busy");

	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("node memory read and written in one cycle");

endmodule

FILE: verif/range_chmin_max_sum_tree_test.sv
module range_chmin_max_sum_tree_test;
	import rcms_pkg::*;

	localparam int NMAX = 1024;
	localparam logic [1:0] ADDR_COUNT = 2'd0;

	typedef struct {
		logic [1:0]  c;
		logic [10:0] l;
		logic [10:0] h;
		logic [30:0] v;
	} word_t;

	typedef struct {
		logic [ANS_W-1:0] ans;
		logic             s;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [1:0] cmd = '0;
	logic [10:0] lo = '0;
	logic [10:0] hi = '0;
	logic [30:0] value = '0;
	logic answer_valid;
	logic [ANS_W-1:0] answer;
	logic is_sum;

	word_t pending_words[$];
	answer_t expected_answers[$];
	logic signed [31:0] elements [1:NMAX];
	int count_reg = NMAX;
	int errors = 0;
	int gap = 0;
	bit taken = 0;
	bit quiet = 0;

	range_chmin_max_sum_tree dut (.*);

	always #6 clk = ~clk;

	function automatic int active_count();
		if (count_reg == 0) return 1;
		if (count_reg > NMAX) return NMAX;
		return count_reg;
	endfunction

	task automatic tree_apply(input word_t w);
		int n, a, b;
		logic [ANS_W-1:0] acc;
		answer_t r;
		n = active_count();
		a = (w.l < 1) ? 1 : w.l;
		b = (w.h > n) ? n : w.h;
		acc = '0;
		if (w.c == CMD_LOAD) begin
			if (w.l >= 1 && w.l <= n) elements[w.l] = {1'b0, w.v};
		end else begin
			for (int i = a; i <= b; i++) begin
				if (w.c == CMD_CHMIN) begin
					if (elements[i] > $signed({1'b0, w.v})) elements[i] = {1'b0, w.v};
				end else if (w.c == CMD_MAXQ) begin
					if (elements[i] > 0 && elements[i] > $signed({1'b0, acc[30:0]}))
						acc = ANS_W'(elements[i]);
				end else if (elements[i] >= 0) begin
					acc = acc + ANS_W'(elements[i]);
				end
			end
			if (w.c != CMD_CHMIN) begin
				r.ans = acc;
				r.s = (w.c == CMD_SUMQ);
				expected_answers.push_back(r);
			end
		end
	endtask

	always @(posedge clk) begin
		answer_t e;
		taken = 0;
		if (arst_n) begin
			if (answer_valid) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected word answer=%0d is_sum=%0d", $time, answer, is_sum);
					errors++;
				end else begin
					e = expected_answers.pop_front();
					if (answer !== e.ans) begin
						$display("%0t: answer expected %0d actual %0d", $time, e.ans, answer);
						errors++;
					end
					if (is_sum !== e.s) begin
						$display("%0t: is_sum expected %0d actual %0d", $time, e.s, is_sum);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				tree_apply('{cmd, lo, hi, value});
				taken = 1;
			end
		end
	end

	always @(negedge clk) begin
		word_t w;
		if (!start || taken) begin
			if (gap > 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				cmd <= w.c;
				lo <= w.l;
				hi <= w.h;
				value <= w.v;
				start <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 10);
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic add_word(input logic [1:0] c, input int l, input int h, input logic [30:0] v);
		pending_words.push_back('{c, l[10:0], h[10:0], v});
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || start || expected_answers.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		for (int q = 0; q < 16; q++) begin
			@(posedge clk);
			if (busy) q = 0;
		end
	endtask

	task automatic write_count(input int n);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_COUNT;
		pwdata <= n;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		count_reg = n & 32'h7FF;
	endtask

	function automatic int pick_index(input int n);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r < 3) return $urandom_range(0, 2047);
		return $urandom_range(1, n);
	endfunction

	function automatic logic [30:0] pick_value();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0) return 31'($urandom_range(0, 20));
		if (r == 1) return 31'(32'h7FFFFFF0 + $urandom_range(0, 15));
		return 31'($urandom);
	endfunction

	task automatic random_words(input int total);
		int n, a, b, t;
		logic [1:0] c;
		n = active_count();
		for (int i = 0; i < total; i++) begin
			c = 2'($urandom_range(0, 3));
			a = pick_index(n);
			b = pick_index(n);
			if ($urandom_range(0, 4) != 0 && a > b) begin
				t = a;
				a = b;
				b = t;
			end
			add_word(c, a, b, pick_value());
		end
	endtask

	task automatic reload(input int n);
		for (int i = 1; i <= n; i++) add_word(CMD_LOAD, i, 0, pick_value());
	endtask

	initial begin
		for (int i = 1; i <= NMAX; i++) elements[i] = -1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_word(CMD_MAXQ, 1, 1024, 0);
		add_word(CMD_SUMQ, 0, 2047, 0);
		add_word(CMD_CHMIN, 1, 1024, 0);
		add_word(CMD_LOAD, 1, 0, 31'h7FFFFFFF);
		add_word(CMD_LOAD, 1024, 0, 31'h7FFFFFFF);
		add_word(CMD_LOAD, 512, 0, 0);
		add_word(CMD_LOAD, 0, 0, 5);
		add_word(CMD_LOAD, 1025, 0, 5);
		add_word(CMD_LOAD, 2047, 0, 5);
		add_word(CMD_SUMQ, 1, 1024, 0);
		add_word(CMD_MAXQ, 0, 2047, 0);
		add_word(CMD_MAXQ, 600, 500, 0);
		add_word(CMD_SUMQ, 2047, 1, 0);
		add_word(CMD_CHMIN, 600, 500, 0);
		add_word(CMD_CHMIN, 1, 1024, 31'h7FFFFFFF);
		add_word(CMD_CHMIN, 2, 1023, 7);
		add_word(CMD_CHMIN, 1, 1024, 1000);
		add_word(CMD_MAXQ, 1, 1024, 0);
		add_word(CMD_SUMQ, 1, 1024, 0);
		add_word(CMD_CHMIN, 1, 1, 0);
		add_word(CMD_MAXQ, 1, 1, 0);
		add_word(CMD_SUMQ, 1024, 1024, 0);
		drain();

		write_count(2047);
		random_words(250);
		drain();
		random_words(150);
		drain();

		write_count(0);
		reload(1);
		random_words(120);
		drain();

		write_count(9);
		reload(9);
		random_words(300);
		drain();

		write_count(100);
		reload(100);
		random_words(500);
		drain();
		quiet = 1;
		random_words(100);
		drain();
		repeat (300) @(posedge clk);

		if (errors == 0 && expected_answers.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#(12 * 8000000);
		$display("FAILURE");
		$finish;
	end

endmodule
